FILE: hdl/frpl_pkg.sv
// Shared types and constants for the four-rotor ramped phase LFO.
package frpl_pkg;

	localparam int LANES      = 4;
	localparam int STEP_W     = 24;
	localparam int LANE_W     = 16;
	localparam int VARI_W     = 17;
	localparam int OUT_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int ALU_W      = 64;

	localparam logic [STEP_W-1:0] MASK24    = 24'hFFFFFF;
	localparam logic [STEP_W-1:0] PARK_BASE = 24'h400000;
	localparam logic [VARI_W-1:0] VARI_ONE  = 17'h10000;

	// item opcodes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SET  = 1'b1;

	// target modes
	localparam logic [1:0] TGT_SLOW = 2'd0;
	localparam logic [1:0] TGT_FAST = 2'd1;
	localparam logic [1:0] TGT_VARI = 2'd2;
	localparam logic [1:0] TGT_STOP = 2'd3;

	// per-rotor ramp state
	localparam logic [1:0] FADE_STOPPED = 2'd0;
	localparam logic [1:0] FADE_UP      = 2'd1;
	localparam logic [1:0] FADE_DOWN    = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd3;

	// shared unit operations
	localparam logic ALU_MUL = 1'b0;
	localparam logic ALU_DIV = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [1:0]        target_mode;
		logic [VARI_W-1:0] vari_speed;
	} item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] left_0;
		logic signed [OUT_W-1:0] left_1;
		logic signed [OUT_W-1:0] left_2;
		logic signed [OUT_W-1:0] left_3;
		logic signed [OUT_W-1:0] right_0;
		logic signed [OUT_W-1:0] right_1;
		logic signed [OUT_W-1:0] right_2;
		logic signed [OUT_W-1:0] right_3;
	} result_t;

	typedef struct packed {
		logic start;
		logic op;
	} alu_ctl_t;

	typedef struct packed {
		logic [1:0] rotor;
		logic [1:0] mode;
	} qent_t;

endpackage

FILE: hdl/frpl_alu.sv
// Shared serial unit: shift-add multiply (32 steps) and restoring divide (64 steps).
module frpl_alu (
	input  logic                       clk,
	input  logic                       arst_n,
	input  frpl_pkg::alu_ctl_t         ctl,
	input  logic [frpl_pkg::ALU_W-1:0] a,
	input  logic [frpl_pkg::ALU_W-1:0] b,
	output logic [frpl_pkg::ALU_W-1:0] result,
	output logic                       done
);
	import frpl_pkg::*;

	localparam int CNT_W     = $clog2(ALU_W);
	localparam int MUL_STEPS = ALU_W / 2;

	logic             busy_q, op_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ALU_W-1:0] acc_q, x_q, y_q, rem_q;
	logic [ALU_W:0]   rem_sh;
	logic             fits, last;

	// one divide step and end of op
	always_comb begin
		rem_sh = {rem_q, x_q[ALU_W-1]};
		fits   = rem_sh >= {1'b0, y_q};
		last   = (op_q == ALU_MUL) ? (cnt_q == CNT_W'(MUL_STEPS - 1))
		                           : (cnt_q == CNT_W'(ALU_W - 1));
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= ALU_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				op_q   <= ctl.op;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
			x_q   <= a;
			y_q   <= b;
			rem_q <= '0;
		end else if (busy_q) begin
			if (op_q == ALU_MUL) begin
				if (y_q[0]) acc_q <= acc_q + x_q;
				x_q <= x_q << 1;
				y_q <= y_q >> 1;
			end else begin
				acc_q <= {acc_q[ALU_W-2:0], fits};
				x_q   <= x_q << 1;
				rem_q <= fits ? ALU_W'(rem_sh - {1'b0, y_q}) : rem_sh[ALU_W-1:0];
			end
		end
	end

	assign result = acc_q;
	assign done   = done_q;

endmodule

FILE: hdl/four_rotor_ramped_phase_lfo.sv
// Four-rotor ramped phase LFO: sequencer, rotor state, ramp queue and sine table.
//
//  channel  | dir | handshake                 | payload
//  item     | in  | item_valid / item_ready   | item (opcode, target_mode, vari_speed)
//  result   | out | result_valid/result_ready | result (left_0..3, right_0..3)
//  cfg      | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One item at a time, not ready while busy. A tick updates each rotor in turn, with a serial
// multiply for a ramping rotor. Starting a queued ramp adds a multiply and two divides; a stop
// ramp adds two more multiplies and a divide. A set-target item visits each rotor, with a
// multiply per rotor for varispeed. An offset write scans the rotors. Async reset; no clearing pass.
// A waiting result does not block the next item; a finished tick waits only on an untaken one.
module four_rotor_ramped_phase_lfo #(
	parameter int ROTORS           = 4,
	parameter int QUEUE_DEPTH      = 16,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  frpl_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output frpl_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [frpl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [frpl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import frpl_pkg::*;

	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int QIDX_W  = $clog2(QUEUE_DEPTH);
	localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int SPROD_W = 23 + IDX_W;
	localparam logic [1:0] ROT_LAST = 2'(ROTORS - 1);
	localparam longint Q30 = 64'sd1073741824;

	localparam logic [4:0] S_IDLE       = 5'd0;
	localparam logic [4:0] S_CFG_SCAN   = 5'd1;
	localparam logic [4:0] S_SET_TGT    = 5'd2;
	localparam logic [4:0] S_POP        = 5'd3;
	localparam logic [4:0] S_RS_BEGIN   = 5'd4;
	localparam logic [4:0] S_RS_MUL_NUM = 5'd5;
	localparam logic [4:0] S_RS_DIV_N   = 5'd6;
	localparam logic [4:0] S_RS_DIV_D   = 5'd7;
	localparam logic [4:0] S_RS_MUL_ROT = 5'd8;
	localparam logic [4:0] S_RS_MUL_SS  = 5'd9;
	localparam logic [4:0] S_RS_DIV_SS  = 5'd10;
	localparam logic [4:0] S_UPD_MUL    = 5'd11;
	localparam logic [4:0] S_UPD_APPLY  = 5'd12;
	localparam logic [4:0] S_SIN_L      = 5'd13;
	localparam logic [4:0] S_SIN_R      = 5'd14;
	localparam logic [4:0] S_SIN_D      = 5'd15;
	localparam logic [4:0] S_OUT        = 5'd16;

	// quarter-wave table, built at elaboration
	function automatic longint mulq(input longint x, input longint y);
		return (x * y) / Q30;
	endfunction

	function automatic logic [14:0] quarter_sine(input int idx);
		longint x, x2, p;
		x  = (longint'(idx) * Q30) / SINE_TABLE_DEPTH;
		x2 = mulq(x, x);
		p  = 172272;
		p  = -5026995 + mulq(x2, p);
		p  = 85569306 + mulq(x2, p);
		p  = -693598668 + mulq(x2, p);
		p  = 1686629713 + mulq(x2, p);
		p  = mulq(x, p);
		p  = (p + 16384) / 32768;
		if (p > 32767) p = 32767;
		if (p < 0) p = 0;
		return 15'(p);
	endfunction

	logic [14:0] sine_rom [SINE_TABLE_DEPTH+1];
	for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
		assign sine_rom[g] = quarter_sine(g);
	end

	// control and architectural state
	logic [4:0]            state_q;
	logic                  issued_q;
	logic [CFG_DATA_W-1:0] slow_q, fast_q, ramp_q;
	logic [STEP_W-1:0]     offset_q;
	logic [STEP_W-1:0]     phase_q [LANES];
	logic [STEP_W-1:0]     cur_q [LANES];
	logic [STEP_W-1:0]     start_q [LANES];
	logic [STEP_W-1:0]     elapsed_q [LANES];
	logic [STEP_W-1:0]     tgt_q [LANES];
	logic [STEP_W-1:0]     dmag_q [LANES];
	logic                  dneg_q [LANES];
	logic [1:0]            fade_q [LANES];
	logic [QCNT_W-1:0]     qcnt_q;
	logic [1:0]            active_q;
	logic [VARI_W-1:0]     active_vari_q;
	logic [1:0]            rsel_q, mode_q;
	logic [VARI_W-1:0]     vari_q;
	logic                  ov_q;

	// queue entries and work registers
	qent_t                 qmem [QUEUE_DEPTH];
	logic [STEP_W-1:0]     diff_q, n_q, ph_q;
	logic                  down_q, neg_q;
	logic [ALU_W-1:0]      num_q, den_q;
	logic [47:0]           rot_q, prod_q;
	logic [14:0]           rom_q;
	logic signed [OUT_W-1:0] left_a [LANES];
	logic signed [OUT_W-1:0] right_a [LANES];
	result_t               out_q;

	// shared unit
	alu_ctl_t         alu_ctl;
	logic [ALU_W-1:0] alu_a, alu_b, alu_res;
	logic             alu_done, fin;

	frpl_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.a      (alu_a),
		.b      (alu_b),
		.result (alu_res),
		.done   (alu_done)
	);

	// selected rotor view
	logic [STEP_W-1:0] cur_w, tgt_w, phase_w, start_w, el_w, dmag_w, park_w, diff_w;
	logic [LANE_W-1:0] slow_l, fast_l, ramp_l, ref_w;
	logic [1:0]        fade_w;
	logic              dneg_w, down_w;
	logic [VARI_W-1:0] vsat;

	always_comb begin
		cur_w   = cur_q[rsel_q];
		tgt_w   = tgt_q[rsel_q];
		phase_w = phase_q[rsel_q];
		start_w = start_q[rsel_q];
		el_w    = elapsed_q[rsel_q];
		dmag_w  = dmag_q[rsel_q];
		dneg_w  = dneg_q[rsel_q];
		fade_w  = fade_q[rsel_q];
		slow_l  = slow_q[{rsel_q, 4'b0} +: LANE_W];
		fast_l  = fast_q[{rsel_q, 4'b0} +: LANE_W];
		ramp_l  = ramp_q[{rsel_q, 4'b0} +: LANE_W];
		park_w  = PARK_BASE - {1'b0, offset_q[STEP_W-1:1]};
		down_w  = tgt_w < cur_w;
		ref_w   = (!down_w && mode_q == TGT_SLOW) ? slow_l : fast_l;
		diff_w  = down_w ? cur_w - tgt_w : tgt_w - cur_w;
		vsat    = (item.vari_speed > VARI_ONE) ? VARI_ONE : item.vari_speed;
	end

	// ramp length terms after R*diff
	logic [39:0] num40;
	logic [42:0] numk;
	logic [17:0] den18;
	logic [STEP_W-1:0] n_w, d_w;
	logic [47:0] rot0;
	logic [STEP_W-1:0] pos_w;
	logic [24:0] adj_w;

	always_comb begin
		num40 = alu_res[39:0];
		numk  = (down_q && mode_q != TGT_SLOW) ? 43'({num40, 2'b0}) + 43'(num40) : 43'(num40);
		if (!down_q) den18 = {2'b0, ref_w};
		else if (mode_q == TGT_SLOW) den18 = {1'b0, ref_w, 1'b0};
		else den18 = {ref_w, 2'b0};
		if (alu_res == '0) n_w = STEP_W'(1);
		else if (alu_res > ALU_W'(MASK24)) n_w = MASK24;
		else n_w = alu_res[STEP_W-1:0];
		d_w   = (alu_res == '0) ? STEP_W'(1) : alu_res[STEP_W-1:0];
		// stop ramp: distance covered, then stretch to the park point
		rot0  = alu_res[48:1];
		pos_w = phase_w + rot0[STEP_W-1:0];
		adj_w = (pos_w < park_w) ? {1'b0, park_w - pos_w} : ({1'b1, park_w} - {1'b0, pos_w});
	end

	// ramp step and clamp
	logic [39:0]       x40;
	logic [40:0]       up_sum;
	logic [STEP_W-1:0] v_w, cv_w, cfin_w, pnew_w;
	logic              end_dn, end_up;

	always_comb begin
		x40    = prod_q[47:8];
		up_sum = {17'b0, start_w} + {1'b0, x40};
		if (dneg_w) v_w = (x40 > {16'b0, start_w}) ? '0 : start_w - x40[STEP_W-1:0];
		else v_w = (up_sum > 41'(MASK24)) ? MASK24 : up_sum[STEP_W-1:0];
		cv_w   = (dmag_w != '0) ? v_w : cur_w;
		end_dn = (fade_w == FADE_DOWN) && (cv_w <= tgt_w);
		end_up = (fade_w == FADE_UP) && (cv_w >= tgt_w);
		cfin_w = (end_dn || end_up) ? tgt_w : cv_w;
		pnew_w = ((end_dn && tgt_w == '0) ? park_w : phase_w) + cfin_w;
	end

	// sine address
	logic [STEP_W-1:0]  sph;
	logic [SPROD_W-1:0] sprod;
	logic [IDX_W-1:0]   sidx, rom_addr;
	logic [OUT_W-1:0]   smag;
	logic signed [OUT_W-1:0] svalue;

	always_comb begin
		sph      = (state_q == S_SIN_L) ? ph_q : ph_q + offset_q;
		sprod    = SPROD_W'(sph[21:0]) * SPROD_W'(SINE_TABLE_DEPTH) + SPROD_W'(22'h200000);
		sidx     = sprod[22 +: IDX_W];
		rom_addr = sph[22] ? IDX_W'(SINE_TABLE_DEPTH) - sidx : sidx;
		smag     = {1'b0, rom_q};
		svalue   = neg_q ? -$signed(smag) : $signed(smag);
	end

	// shared unit operands
	logic alu_need;

	always_comb begin
		alu_a    = '0;
		alu_b    = '0;
		alu_need = 1'b1;
		alu_ctl.op = ALU_MUL;
		case (state_q)
			S_SET_TGT: begin
				alu_a    = ALU_W'(fast_l);
				alu_b    = ALU_W'(vari_q);
				alu_need = (mode_q == TGT_VARI);
			end
			S_RS_MUL_NUM: begin
				alu_a = ALU_W'(ramp_l);
				alu_b = ALU_W'(diff_q);
			end
			S_RS_DIV_N, S_RS_DIV_SS: begin
				alu_a = num_q;
				alu_b = den_q;
				alu_ctl.op = ALU_DIV;
			end
			S_RS_DIV_D: begin
				alu_a = ALU_W'({diff_q, 8'b0});
				alu_b = ALU_W'(n_q);
				alu_ctl.op = ALU_DIV;
			end
			S_RS_MUL_ROT: begin
				alu_a = ALU_W'(cur_w);
				alu_b = ALU_W'(n_q) + ALU_W'(1);
			end
			S_RS_MUL_SS: begin
				alu_a = ALU_W'(cur_w);
				alu_b = ALU_W'(cur_w);
			end
			S_UPD_MUL: begin
				alu_a    = ALU_W'(dmag_w);
				alu_b    = ALU_W'(el_w);
				alu_need = (dmag_w != '0);
			end
			default: alu_need = 1'b0;
		endcase
		alu_ctl.start = alu_need && !issued_q;
		fin = issued_q && alu_done;
	end

	// queue push / pop
	logic  set_go, push_en, push_ok, pop_en;
	qent_t push_val, head;

	always_comb begin
		set_go   = (state_q == S_SET_TGT) && ((mode_q != TGT_VARI) || fin);
		push_en  = set_go ||
		           ((state_q == S_CFG_SCAN) && tgt_w == '0 && fade_w == FADE_DOWN);
		push_val.rotor = rsel_q;
		push_val.mode  = (state_q == S_CFG_SCAN) ? TGT_STOP : mode_q;
		push_ok  = push_en && (qcnt_q < QCNT_W'(QUEUE_DEPTH));
		pop_en   = (state_q == S_POP) && (qcnt_q != '0);
		head     = qmem[0];
	end

	always_ff @(posedge clk) begin
		if (pop_en) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) qmem[i] <= qmem[i+1];
		end else if (push_ok) begin
			qmem[qcnt_q[QIDX_W-1:0]] <= push_val;
		end
	end

	// sequencer and rotor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			issued_q      <= 1'b0;
			slow_q        <= '0;
			fast_q        <= '0;
			ramp_q        <= '0;
			offset_q      <= '0;
			qcnt_q        <= '0;
			active_q      <= TGT_STOP;
			active_vari_q <= '0;
			rsel_q        <= '0;
			mode_q        <= TGT_SLOW;
			vari_q        <= '0;
			ov_q          <= 1'b0;
			for (int r = 0; r < LANES; r++) begin
				phase_q[r]   <= PARK_BASE;
				cur_q[r]     <= '0;
				start_q[r]   <= '0;
				elapsed_q[r] <= '0;
				tgt_q[r]     <= '0;
				dmag_q[r]    <= '0;
				dneg_q[r]    <= 1'b0;
				fade_q[r]    <= FADE_STOPPED;
			end
		end else begin
			if (alu_ctl.start) issued_q <= 1'b1;
			else if (alu_done) issued_q <= 1'b0;

			if (push_ok) qcnt_q <= qcnt_q + 1'b1;
			else if (pop_en) qcnt_q <= qcnt_q - 1'b1;

			if (state_q == S_OUT && (!ov_q || result_ready)) ov_q <= 1'b1;
			else if (result_ready) ov_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						case (cfg_index)
							CFG_SLOW: slow_q <= cfg_data;
							CFG_FAST: fast_q <= cfg_data;
							CFG_RAMP: ramp_q <= cfg_data;
							CFG_OFFSET: begin
								offset_q <= cfg_data[STEP_W-1:0];
								rsel_q   <= '0;
								state_q  <= S_CFG_SCAN;
							end
							default: ;
						endcase
					end else if (item_valid) begin
						if (item.opcode == OP_TICK) begin
							state_q <= S_POP;
						end else if (item.target_mode != active_q || vsat != active_vari_q) begin
							mode_q  <= item.target_mode;
							vari_q  <= vsat;
							rsel_q  <= ROT_LAST;
							state_q <= S_SET_TGT;
						end
					end
				end
				// offset write: re-park stopped rotors, re-aim rotors stopping
				S_CFG_SCAN: begin
					if (tgt_w == '0 && fade_w == FADE_STOPPED) phase_q[rsel_q] <= park_w;
					rsel_q <= rsel_q + 1'b1;
					if (rsel_q == ROT_LAST) state_q <= S_IDLE;
				end
				// targets and ramp starts, high rotor first
				S_SET_TGT: begin
					if (set_go) begin
						case (mode_q)
							TGT_SLOW: tgt_q[rsel_q] <= STEP_W'(slow_l);
							TGT_FAST: tgt_q[rsel_q] <= STEP_W'(fast_l);
							TGT_VARI: tgt_q[rsel_q] <= alu_res[39:16];
							default:  tgt_q[rsel_q] <= '0;
						endcase
						if (rsel_q == '0) begin
							active_q      <= mode_q;
							active_vari_q <= vari_q;
							state_q       <= S_IDLE;
						end else begin
							rsel_q <= rsel_q - 1'b1;
						end
					end
				end
				S_POP: begin
					if (qcnt_q != '0 && {1'b0, head.rotor} < 3'(ROTORS)) begin
						rsel_q  <= head.rotor;
						mode_q  <= head.mode;
						state_q <= S_RS_BEGIN;
					end else begin
						rsel_q  <= '0;
						state_q <= S_UPD_MUL;
					end
				end
				S_RS_BEGIN: begin
					start_q[rsel_q]   <= cur_w;
					elapsed_q[rsel_q] <= '0;
					if (tgt_w == cur_w || ref_w == '0) begin
						// nothing to ramp, or jump at once
						cur_q[rsel_q]  <= tgt_w;
						dmag_q[rsel_q] <= '0;
						fade_q[rsel_q] <= FADE_STOPPED;
						if (tgt_w != cur_w && tgt_w == '0) phase_q[rsel_q] <= park_w;
						rsel_q  <= '0;
						state_q <= S_UPD_MUL;
					end else begin
						state_q <= S_RS_MUL_NUM;
					end
				end
				S_RS_MUL_NUM: if (fin) state_q <= S_RS_DIV_N;
				S_RS_DIV_N:   if (fin) state_q <= S_RS_DIV_D;
				S_RS_DIV_D: begin
					if (fin) begin
						dmag_q[rsel_q] <= d_w;
						dneg_q[rsel_q] <= down_q;
						fade_q[rsel_q] <= down_q ? FADE_DOWN : FADE_UP;
						if (down_q && tgt_w == '0) begin
							state_q <= S_RS_MUL_ROT;
						end else begin
							rsel_q  <= '0;
							state_q <= S_UPD_MUL;
						end
					end
				end
				S_RS_MUL_ROT: if (fin) state_q <= S_RS_MUL_SS;
				S_RS_MUL_SS:  if (fin) state_q <= S_RS_DIV_SS;
				S_RS_DIV_SS: begin
					if (fin) begin
						dmag_q[rsel_q] <= d_w;
						rsel_q         <= '0;
						state_q        <= S_UPD_MUL;
					end
				end
				S_UPD_MUL: if (dmag_w == '0 || fin) state_q <= S_UPD_APPLY;
				S_UPD_APPLY: begin
					cur_q[rsel_q]   <= cfin_w;
					phase_q[rsel_q] <= pnew_w;
					if (dmag_w != '0 && el_w != MASK24) elapsed_q[rsel_q] <= el_w + 1'b1;
					if (end_dn || end_up) begin
						dmag_q[rsel_q] <= '0;
						fade_q[rsel_q] <= FADE_STOPPED;
					end
					state_q <= S_SIN_L;
				end
				S_SIN_L: state_q <= S_SIN_R;
				S_SIN_R: state_q <= S_SIN_D;
				S_SIN_D: begin
					if (rsel_q == ROT_LAST) begin
						state_q <= S_OUT;
					end else begin
						rsel_q  <= rsel_q + 1'b1;
						state_q <= S_UPD_MUL;
					end
				end
				S_OUT: if (!ov_q || result_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result assembly
	result_t res_w;

	always_comb begin
		res_w.left_0  = left_a[0];
		res_w.right_0 = right_a[0];
		res_w.left_1  = (ROTORS > 1) ? left_a[1] : '0;
		res_w.right_1 = (ROTORS > 1) ? right_a[1] : '0;
		res_w.left_2  = (ROTORS > 2) ? left_a[2] : '0;
		res_w.right_2 = (ROTORS > 2) ? right_a[2] : '0;
		res_w.left_3  = (ROTORS > 3) ? left_a[3] : '0;
		res_w.right_3 = (ROTORS > 3) ? right_a[3] : '0;
	end

	// work registers, table read, result payload
	always_ff @(posedge clk) begin
		rom_q <= sine_rom[rom_addr];
		case (state_q)
			S_RS_BEGIN: begin
				diff_q <= diff_w;
				down_q <= down_w;
			end
			S_RS_MUL_NUM: begin
				if (fin) begin
					num_q <= ALU_W'(numk) + ALU_W'(den18) - ALU_W'(1);
					den_q <= ALU_W'(den18);
				end
			end
			S_RS_DIV_N:   if (fin) n_q <= n_w;
			S_RS_MUL_ROT: if (fin) rot_q <= rot0 + 48'(adj_w);
			S_RS_MUL_SS: begin
				if (fin) begin
					num_q <= {alu_res[55:0], 8'b0};
					den_q <= ALU_W'(cur_w) + ALU_W'({rot_q, 1'b0});
				end
			end
			S_UPD_MUL:   if (fin) prod_q <= alu_res[47:0];
			S_UPD_APPLY: ph_q <= pnew_w;
			S_SIN_L:     neg_q <= sph[23];
			S_SIN_R: begin
				left_a[rsel_q] <= svalue;
				neg_q          <= sph[23];
			end
			S_SIN_D: right_a[rsel_q] <= svalue;
			S_OUT:   if (!ov_q || result_ready) out_q <= res_w;
			default: ;
		endcase
	end

	assign item_ready   = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready    = (state_q == S_IDLE);
	assign result_valid = ov_q;
	assign result       = out_q;

endmodule
